// File: sv/psx_pkg.sv
// Package for the printable string extractor: payload structs, config struct,
// encoding codes, class enable bit positions and counter width.
// No dependencies.
`default_nettype none

package psx_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_BITS    = 32;

  localparam logic [1:0] ENC_ASCII   = 2'd0;
  localparam logic [1:0] ENC_UTF16LE = 2'd1;
  localparam logic [1:0] ENC_UTF16BE = 2'd2;

  localparam logic [1:0] REG_CLASS_ENABLES = 2'd0;
  localparam logic [1:0] REG_MIN_RUN       = 2'd1;
  localparam logic [1:0] REG_ENCODING      = 2'd2;
  localparam logic [1:0] REG_NEED_NULL_END = 2'd3;

  localparam int CLS_LOWER  = 0;
  localparam int CLS_UPPER  = 1;
  localparam int CLS_DIGIT  = 2;
  localparam int CLS_SPACE  = 3;
  localparam int CLS_UNDER  = 4;
  localparam int CLS_SYMBOL = 5;
  localparam int CLS_LF     = 6;

  localparam logic [6:0]  CLASS_ENABLES_RST = 7'h7F;
  localparam logic [15:0] MIN_RUN_RST       = 16'd4;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] run_offset;
    logic [OUT_BITS-1:0] run_length;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  class_enables;
    logic [15:0] min_run;
    logic [1:0]  encoding;
    logic        need_null_end;
  } cfg_t;

  function automatic logic [OUT_BITS-1:0] to_out(input offset_t v);
    logic [OFFSET_BITS+OUT_BITS-1:0] ext;
    ext = {{OUT_BITS{1'b0}}, v};
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/psx_classify.sv
// Byte classifier: tests one byte against the enabled character classes
// and applies the UTF-16 zero byte rule. Depends on psx_pkg.
`default_nettype none

module psx_classify
  import psx_pkg::*;
(
  input  var logic [7:0] data_byte,
  input  var cfg_t       cfg,
  input  var logic       count_odd,
  output var logic       byte_ok
);

  logic lower, upper, digit, blank, under, punct, lf, cls_ok, is_zero;

  always_comb begin
    lower  = data_byte >= 8'h61 && data_byte <= 8'h7A;
    upper  = data_byte >= 8'h41 && data_byte <= 8'h5A;
    digit  = data_byte >= 8'h30 && data_byte <= 8'h39;
    blank  = data_byte == 8'h20 || data_byte == 8'h09 ||
             data_byte == 8'h0B || data_byte == 8'h0C;
    under  = data_byte == 8'h5F;
    punct  = (data_byte >= 8'h21 && data_byte <= 8'h2F) ||
             (data_byte >= 8'h3A && data_byte <= 8'h40) ||
             (data_byte >= 8'h5B && data_byte <= 8'h60) ||
             (data_byte >= 8'h7B && data_byte <= 8'h7E);
    lf     = data_byte == 8'h0D || data_byte == 8'h0A;
    is_zero = data_byte == 8'h00;
    cls_ok = (cfg.class_enables[CLS_LOWER]  && lower) ||
             (cfg.class_enables[CLS_UPPER]  && upper) ||
             (cfg.class_enables[CLS_DIGIT]  && digit) ||
             (cfg.class_enables[CLS_SPACE]  && blank) ||
             (cfg.class_enables[CLS_UNDER]  && under) ||
             (cfg.class_enables[CLS_SYMBOL] && punct) ||
             (cfg.class_enables[CLS_LF]     && lf);
    byte_ok = cls_ok;
    case (cfg.encoding)
      ENC_UTF16LE: if (count_odd) byte_ok = is_zero;
      ENC_UTF16BE: if (!count_odd) byte_ok = is_zero;
      default: byte_ok = cls_ok;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/psx_run_tracker.sv
// Run tracker: keeps run start offset and byte count, decides when a run
// ends and whether it is reported. Depends on psx_pkg and psx_classify.
`default_nettype none

module psx_run_tracker
  import psx_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst,
  input  var logic      step,
  input  var in_item_t  item,
  input  var cfg_t      cfg,
  output var logic      emit,
  output var out_item_t result
);

  offset_t start_offset, start_offset_next;
  offset_t char_count, char_count_next;
  offset_t count_inc, need;
  logic    byte_ok, run_end;

  psx_classify u_classify (
    .data_byte (item.data_byte),
    .cfg       (cfg),
    .count_odd (char_count[0]),
    .byte_ok   (byte_ok)
  );

  always_comb begin
    need = (cfg.min_run == 16'd0) ? offset_t'(1) : offset_t'(cfg.min_run);
    count_inc = byte_ok ? char_count + offset_t'(1) : char_count;
    run_end = !byte_ok || item.region_end;
    emit = run_end && count_inc >= need &&
           (!cfg.need_null_end || item.data_byte == 8'h00);
    result.run_offset = to_out(start_offset);
    result.run_length = to_out(count_inc);
    start_offset_next = start_offset;
    char_count_next = count_inc;
    if (run_end) begin
      start_offset_next = start_offset + count_inc + offset_t'(1);
      char_count_next = '0;
    end
    if (item.region_end) begin
      start_offset_next = '0;
      char_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      char_count <= '0;
    end else if (step) begin
      start_offset <= start_offset_next;
      char_count <= char_count_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/printable_string_extractor.sv
// Top level of the printable string extractor: config registers, request
// input register and result register. Depends on psx_pkg, psx_run_tracker.
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid / in_stall   | in_item_t  (data_byte, region_end)
//   out     | result    | out_valid / out_stall | out_item_t (run_offset, run_length)
//   cfg     | write     | cfg_write             | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; request, then result, are registered.
// The run counter update in psx_run_tracker is a loop through its own registers.
// Reset clears config to defaults, both counters and both valid flags.
// A stalled result holds the request register; in_stall rises only then.
`default_nettype none

module printable_string_extractor
  import psx_pkg::*;
(
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        in_valid,
  output var logic        in_stall,
  input  var in_item_t    in_data,
  output var logic        out_valid,
  input  var logic        out_stall,
  output var out_item_t   out_data,
  input  var logic        cfg_write,
  input  var logic [1:0]  cfg_index,
  input  var logic [15:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_full, advance, emit;
  out_item_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_enables <= CLASS_ENABLES_RST;
      cfg.min_run <= MIN_RUN_RST;
      cfg.encoding <= ENC_ASCII;
      cfg.need_null_end <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLASS_ENABLES: cfg.class_enables <= cfg_data[6:0];
        REG_MIN_RUN:       cfg.min_run <= cfg_data;
        REG_ENCODING:      cfg.encoding <= cfg_data[1:0];
        REG_NEED_NULL_END: cfg.need_null_end <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  psx_run_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// File: sv/psx_checker.sv
// Port checker for printable_string_extractor, attached by bind.
// Depends on psx_pkg.
`default_nettype none

module psx_checker
  import psx_pkg::*;
(
  input var logic        clk,
  input var logic        rst,
  input var logic        in_valid,
  input var logic        in_stall,
  input var logic        out_valid,
  input var logic        out_stall,
  input var out_item_t   out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.run_length != '0)
    else $error("empty run reported");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a request two cycles earlier");

endmodule

bind printable_string_extractor psx_checker u_psx_checker (.*);

`default_nettype wire
